>>> hw/rtl/ucp_pkg.sv
// Shared types, constants and the window judge for unreachable cell pruning.
package ucp_pkg;

  localparam int KIND_W        = 3;
  localparam int WIN_CELLS     = 9;
  localparam int WIN_CENTRE    = 4;
  localparam int MAX_WIDTH_DEF = 32;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int ROW_W         = 12;
  localparam int GW_W          = 6;
  localparam int GH_W          = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int NUM_SLOTS     = 4;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_NONE = 3'd0;

  localparam logic [GW_W-1:0]   WIDTH_RST  = 6'd32;
  localparam logic [GH_W-1:0]   HEIGHT_RST = 13'd32;
  localparam kind_t             TARGET_RST = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_TARGET_KIND = 2'd2
  } cfg_reg_t;

  // [row][col], row 2 is the newest row, col 2 the newest column
  typedef logic [2:0][2:0][KIND_W-1:0] win_t;

  // Results caused by one item, in emit order: slot 0 first
  typedef struct packed {
    logic [NUM_SLOTS-1:0]             mask;
    logic [NUM_SLOTS-1:0][KIND_W-1:0] kinds;
    logic                             last;
  } bundle_t;

  // Pruned kind of the window centre; with lower set the window is read one
  // row down and the row below the bottom counts as none.
  function automatic kind_t judge(input win_t w, input logic lower, input kind_t target);
    logic [WIN_CELLS-1:0][KIND_W-1:0] cells;
    logic clear;
    int src;
    clear = 1'b1;
    for (int r = 0; r < 3; r++) begin
      src = lower ? r + 1 : r;
      for (int c = 0; c < 3; c++) begin
        cells[r*3+c] = (src <= 2) ? w[src][c] : KIND_NONE;
      end
    end
    for (int k = 0; k < WIN_CELLS; k++) begin
      if (cells[k] != KIND_NONE && cells[k] != target) clear = 1'b0;
    end
    if (cells[WIN_CENTRE] != target) return cells[WIN_CENTRE];
    return clear ? KIND_NONE : cells[WIN_CENTRE];
  endfunction

endpackage

>>> hw/rtl/ucp_front.sv
// Front end: config registers, line store, 3x3 window and result bundling.
module ucp_front #(
  parameter int MAX_WIDTH = ucp_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ucp_pkg::kind_t               in_cell_kind,
  input  logic                         cfg_wr_en,
  input  logic [ucp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ucp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                         q_full,
  output logic                         q_push,
  output ucp_pkg::bundle_t             q_bundle
);
  import ucp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [GW_W-1:0]  width_r;
  logic [GH_W-1:0]  height_r;
  kind_t            target_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  win_t             win_r, win_nxt;

  // Each entry holds {upper row, middle row} for one column
  logic [2*KIND_W-1:0] mem [MAX_WIDTH];
  logic [2*KIND_W-1:0] rd_r;

  logic [GH_W-1:0] w_eff, h_eff;
  logic accept, cfg_hit, row_end, last_row, has_prev, row_ge1, row_ge2;
  kind_t top, mid;
  win_t base, sh1, sh2;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_wr_en && (cfg_index == REG_GRID_WIDTH ||
                    cfg_index == REG_GRID_HEIGHT || cfg_index == REG_TARGET_KIND);

  always_comb begin
    if (width_r == '0) w_eff = GH_W'(1);
    else if (GH_W'(width_r) > GH_W'(MAX_WIDTH)) w_eff = GH_W'(MAX_WIDTH);
    else w_eff = GH_W'(width_r);
    if (height_r == '0) h_eff = GH_W'(1);
    else if (height_r > GH_W'(HEIGHT_LIMIT)) h_eff = GH_W'(HEIGHT_LIMIT);
    else h_eff = height_r;
  end

  assign row_end  = GH_W'(col_r) == w_eff - GH_W'(1);
  assign last_row = GH_W'(row_r) == h_eff - GH_W'(1);
  assign has_prev = col_r != '0;
  assign row_ge1  = row_r != '0;
  assign row_ge2  = row_r >= ROW_W'(2);
  assign top      = row_ge2 ? rd_r[2*KIND_W-1:KIND_W] : KIND_NONE;
  assign mid      = row_ge1 ? rd_r[KIND_W-1:0] : KIND_NONE;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        base[r][c] = (col_r == '0) ? KIND_NONE : win_r[r][c];
      end
    end
    for (int r = 0; r < 3; r++) begin
      sh1[r][0] = base[r][1];
      sh1[r][1] = base[r][2];
    end
    sh1[0][2] = top;
    sh1[1][2] = mid;
    sh1[2][2] = in_cell_kind;
    // Row end: shift the off-grid column in to finish the last cell
    for (int r = 0; r < 3; r++) begin
      sh2[r][0] = sh1[r][1];
      sh2[r][1] = sh1[r][2];
      sh2[r][2] = KIND_NONE;
    end
  end

  always_comb begin
    q_bundle.kinds[0] = judge(sh1, 1'b0, target_r);
    q_bundle.kinds[1] = judge(sh2, 1'b0, target_r);
    q_bundle.kinds[2] = judge(sh1, 1'b1, target_r);
    q_bundle.kinds[3] = judge(sh2, 1'b1, target_r);
    q_bundle.mask[0]  = row_ge1 && has_prev;
    q_bundle.mask[1]  = row_ge1 && row_end;
    q_bundle.mask[2]  = last_row && has_prev;
    q_bundle.mask[3]  = last_row && row_end;
    q_bundle.last     = last_row && row_end;
  end

  assign q_push = accept && (q_bundle.mask != '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    win_nxt = win_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      win_nxt = row_end ? sh2 : sh1;
      if (row_end && last_row) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      target_r <= TARGET_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GRID_WIDTH:  width_r  <= cfg_wdata[GW_W-1:0];
          REG_GRID_HEIGHT: height_r <= cfg_wdata[GH_W-1:0];
          REG_TARGET_KIND: target_r <= cfg_wdata[KIND_W-1:0];
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // Prefetch the entry of the next column; forward the write when they meet
  always_ff @(posedge clk) begin
    if (accept) mem[col_r] <= {rd_r[KIND_W-1:0], in_cell_kind};
    if (accept && col_r == col_nxt) rd_r <= {rd_r[KIND_W-1:0], in_cell_kind};
    else rd_r <= mem[col_nxt];
  end

endmodule

>>> hw/rtl/ucp_queue.sv
// Short queue of result bundles between front and back.
module ucp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ucp_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ucp_pkg::bundle_t head
);
  import ucp_pkg::*;

  localparam int QPW = $clog2(QUEUE_DEPTH);

  bundle_t      entries_r [QUEUE_DEPTH];
  logic [QPW:0] wr_ptr_r, rd_ptr_r;

  assign full       = (wr_ptr_r[QPW] != rd_ptr_r[QPW]) &&
                      (wr_ptr_r[QPW-1:0] == rd_ptr_r[QPW-1:0]);
  assign head_valid = wr_ptr_r != rd_ptr_r;
  assign head       = entries_r[rd_ptr_r[QPW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + (QPW+1)'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r[QPW-1:0]] <= push_data;
  end

endmodule

>>> hw/rtl/ucp_back.sv
// Back end: serializes queued bundles into one result item per cycle while out_ready is high.
module ucp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  ucp_pkg::bundle_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ucp_pkg::kind_t   out_kind,
  output logic             out_last
);
  import ucp_pkg::*;

  logic [NUM_SLOTS-1:0] sent_r, remaining, pick;
  logic                 out_valid_r, out_last_r, take, final_pick;
  kind_t                out_kind_r, pick_kind;

  assign remaining = head.mask & ~sent_r;

  // Lowest pending slot goes first
  always_comb begin
    pick      = '0;
    pick_kind = KIND_NONE;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        pick      = NUM_SLOTS'(1) << i;
        pick_kind = head.kinds[i];
      end
    end
  end

  assign final_pick = (remaining & ~pick) == '0;
  assign take       = head_valid && (!out_valid_r || out_ready);
  assign pop        = take && final_pick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        sent_r      <= final_pick ? '0 : (sent_r | pick);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind_r <= pick_kind;
      out_last_r <= head.last && final_pick;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule

>>> hw/rtl/unreachable_cell_pruning_3x3.sv
// Accepts one cell per cycle while in_ready is high and returns at most one result per
// cycle; most cells of the last row give two results each.
// A cell's result is written into the queue when the item that completes its 3x3 window
// (one row plus one cell later) is accepted, and is then registered at the output.
// The grid's final cell releases up to four results at once; a four-bundle queue absorbs
// them and in_ready drops only while that queue is full.
// Reset: 32x32 grid, target kind 2, counters and queue cleared; line store not cleared.
module unreachable_cell_pruning_3x3 #(
  parameter int MAX_WIDTH = ucp_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ucp_pkg::kind_t                 in_cell_kind,
  input  logic                           in_frame_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ucp_pkg::kind_t                 out_kind,
  output logic                           out_last,
  input  logic                           cfg_wr_en,
  input  logic [ucp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ucp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ucp_pkg::*;

  logic    q_push, q_full, q_pop, q_head_valid;
  bundle_t q_bundle, q_head;

  // Grid end comes from the counters; in_frame_end is informational only.

  ucp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cell_kind (in_cell_kind),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_bundle     (q_bundle)
  );

  ucp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_bundle),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ucp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("bundle pushed into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

  a_head_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    q_head_valid |-> q_head.mask != '0)
    else $error("queued bundle carries no result");

  a_last_ends_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_bundle.last |-> q_bundle.mask[NUM_SLOTS-1])
    else $error("grid end without final cell result");

endmodule
